@@ design/twl_pkg.sv @@
// Shared types, byte codes and helper functions for the text whitespace lint block.
// No dependencies; imported by every module of the block.
package twl_pkg;

    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_VT    = 8'h0B;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;

    // Sticky flags collected over one file.
    typedef struct packed {
        logic invalid;
        logic crlf;
        logic trailing;
        logic unusual;
        logic tabs;
    } t_flags;

    // Held context between words of one file.
    typedef struct packed {
        logic [7:0] prev_byte;
        logic [7:0] prev2_byte;
        t_flags     flags;
    } t_state;

    // One result word; the first member sits in the highest bit.
    typedef struct packed {
        logic can_be_fixed;
        logic has_invalid_bytes;
        logic missing_final_lf;
        logic has_crlf;
        logic has_trailing_space;
        logic has_unusual_space;
        logic has_tabs;
    } t_result;

    function automatic logic is_white(input logic [7:0] b);
        is_white = (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_LF) ||
                   (b == BYTE_VT) || (b == BYTE_FF) || (b == BYTE_CR);
    endfunction

endpackage

@@ design/text_whitespace_lint_top.sv @@
// Top level of the text whitespace lint block: input register, held context,
// result register. Depends on twl_pkg and twl_step.
//
//  Channel     | Direction | Carries
//  s_axis      | in        | tdata[7:0] text_byte, tlast end_of_file
//  m_axis      | out       | tdata[6:0] seven flags, one word per file
//
// One byte is taken per cycle unless a final byte waits for a free result register.
// A byte passes the input register and is classified there; a file's result is
// registered as its final byte is taken. The single context register sets that rate.
// Reset (synchronous, active low) empties both registers and clears the context.
// A stalled result only holds back a final byte; other bytes keep flowing.
module text_whitespace_lint_top
    import twl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tlast,   // end_of_file
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] has_tabs, [1] has_unusual_space,
                                         // [2] has_trailing_space, [3] has_crlf,
                                         // [4] missing_final_lf, [5] has_invalid_bytes,
                                         // [6] can_be_fixed, [7] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       out_free;
    logic       in_take;
    logic       s_accept;

    twl_step u_step (
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    // Only a final byte needs room in the result register.
    assign in_take         = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || in_take;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_take && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_take && r_in_last) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_result};

    // A result word only appears after a final byte was classified.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_take && r_in_last))
        else $error("result word without a final byte");

    // The context is clear once a file has ended.
    a_ctx_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_take && r_in_last) |-> (r_state == '0))
        else $error("context not cleared after end of file");

    // Line feeds are never held as context.
    a_no_lf_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.prev_byte != BYTE_LF) && (r_state.prev2_byte != BYTE_LF))
        else $error("line feed held in context");

    // A file with invalid bytes is never marked as fixable.
    a_fix_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.can_be_fixed && r_result.has_invalid_bytes))
        else $error("fixable file with invalid bytes");

endmodule

@@ design/twl_step.sv @@
// Per-byte classification: next held context and the result flags for one byte.
// Depends on twl_pkg.
module twl_step
    import twl_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    logic [7:0] pen;
    logic [7:0] line_end;
    logic       is_ctrl;
    t_flags     f;
    t_state     next_st;

    always_comb begin
        pen      = i_state.prev_byte;
        line_end = pen;
        f        = i_state.flags;
        is_ctrl  = (i_byte < BYTE_SPACE) || (i_byte > BYTE_TILDE);
        next_st.prev_byte = i_byte;

        if ((pen == BYTE_CR) && (i_byte != BYTE_LF)) begin
            f.unusual = 1'b1;
        end

        if (is_ctrl) begin
            if (i_byte == BYTE_LF) begin
                // For a CR-LF ending the byte before the CR ends the line.
                if (pen == BYTE_CR) begin
                    f.crlf   = 1'b1;
                    line_end = i_state.prev2_byte;
                    pen      = 8'h00;
                end
                if (is_white(line_end)) begin
                    f.trailing = 1'b1;
                end
                next_st.prev_byte = 8'h00;
            end else if (i_byte == BYTE_TAB) begin
                f.tabs = 1'b1;
            end else if ((i_byte == BYTE_VT) || (i_byte == BYTE_FF)) begin
                f.unusual = 1'b1;
            end else if (i_byte == BYTE_CR) begin
                if (i_last) begin
                    f.unusual = 1'b1;
                end
            end else begin
                f.invalid = 1'b1;
            end
        end

        next_st.prev2_byte = pen;
        next_st.flags      = f;

        o_result.has_tabs           = f.tabs;
        o_result.has_unusual_space  = f.unusual;
        o_result.has_trailing_space = f.trailing;
        o_result.has_crlf           = f.crlf;
        o_result.missing_final_lf   = (i_byte != BYTE_LF);
        o_result.has_invalid_bytes  = f.invalid;
        o_result.can_be_fixed       = !f.invalid &&
            (f.tabs || f.unusual || f.trailing || f.crlf || (i_byte != BYTE_LF));

        // The context clears after the final byte of a file.
        o_state = i_last ? '0 : next_st;
    end

endmodule

@@ tb/text_whitespace_lint_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for text_whitespace_lint_top: short text files are streamed in a byte
// at a time and every flag word that comes out is compared with a local model of the lint or a pinned word.
// Depends on twl_pkg and the block itself.
module text_whitespace_lint_top_tb;
    import twl_pkg::*;

    localparam int RANDOM_BYTES  = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 300;

    typedef struct {
        logic [7:0] text_byte;
        logic       eof;
        bit         pinned;
        t_result    outcome;
    } t_lint_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata = 8'h00;
    logic       i_s_axis_tlast = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;

    // Model of the lint: held bytes and sticky flags of the current file.
    logic [7:0] held_prev = 8'h00;
    logic [7:0] held_prev2 = 8'h00;
    t_flags     file_flags = '0;

    t_result    pending_results[$];
    logic [7:0] file_bytes[$];
    logic [7:0] want_word;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold_req = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  error_count = 0;
    int  results_checked = 0;
    int  bytes_sent = 0;
    int  files_sent = 0;

    string result_field [8] = '{"has_tabs", "has_unusual_space", "has_trailing_space",
                                "has_crlf", "missing_final_lf", "has_invalid_bytes",
                                "can_be_fixed", "pad"};

    // Pinned words read: can_be_fixed, invalid, no final LF, CR-LF, trailing, unusual, tabs.
    t_lint_row directed_rows [23] = '{
        '{8'h00, 1'b1, 1'b1, 7'b0110000},
        '{8'hFF, 1'b1, 1'b1, 7'b0110000},
        '{BYTE_LF, 1'b1, 1'b1, 7'b0000000},
        '{BYTE_CR, 1'b1, 1'b1, 7'b1010010},
        '{BYTE_TAB, 1'b1, 1'b1, 7'b1010001},
        '{BYTE_VT, 1'b1, 1'b1, 7'b1010010},
        '{BYTE_FF, 1'b1, 1'b1, 7'b1010010},
        '{BYTE_SPACE, 1'b0, 1'b0, 7'b0},
        '{BYTE_LF, 1'b1, 1'b1, 7'b1000100},
        '{BYTE_SPACE, 1'b0, 1'b0, 7'b0},
        '{BYTE_CR, 1'b0, 1'b0, 7'b0},
        '{BYTE_LF, 1'b1, 1'b1, 7'b1001100},
        '{8'h41, 1'b0, 1'b0, 7'b0},
        '{BYTE_CR, 1'b0, 1'b0, 7'b0},
        '{8'h41, 1'b1, 1'b0, 7'b0},
        '{BYTE_TILDE, 1'b0, 1'b0, 7'b0},
        '{8'h7F, 1'b1, 1'b0, 7'b0},
        '{BYTE_CR, 1'b0, 1'b0, 7'b0},
        '{BYTE_CR, 1'b0, 1'b0, 7'b0},
        '{BYTE_LF, 1'b1, 1'b0, 7'b0},
        '{BYTE_CR, 1'b0, 1'b0, 7'b0},
        '{BYTE_LF, 1'b0, 1'b0, 7'b0},
        '{BYTE_LF, 1'b1, 1'b0, 7'b0}
    };

    text_whitespace_lint_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advances the lint model by one byte and gives the flag word when the file ends.
    task automatic lint_byte(input logic [7:0] b, input logic eof,
                             output bit emits, output t_result res);
        logic [7:0] pen;
        logic [7:0] line_end;
        logic [7:0] held;
        t_flags     f;
        pen  = held_prev;
        held = b;
        f    = file_flags;
        if (pen == BYTE_CR && b != BYTE_LF) f.unusual = 1'b1;
        if (b < BYTE_SPACE || b > BYTE_TILDE) begin
            if (b == BYTE_LF) begin
                line_end = pen;
                // For a CR-LF ending the byte before the CR decides.
                if (pen == BYTE_CR) begin
                    f.crlf   = 1'b1;
                    line_end = held_prev2;
                    pen      = 8'h00;
                end
                case (line_end)
                    BYTE_SPACE, BYTE_TAB, BYTE_LF, BYTE_VT, BYTE_FF, BYTE_CR: begin
                        f.trailing = 1'b1;
                    end
                    default: ;
                endcase
                held = 8'h00;
            end else if (b == BYTE_TAB) begin
                f.tabs = 1'b1;
            end else if (b == BYTE_VT || b == BYTE_FF) begin
                f.unusual = 1'b1;
            end else if (b == BYTE_CR) begin
                if (eof) f.unusual = 1'b1;
            end else begin
                f.invalid = 1'b1;
            end
        end
        held_prev2 = pen;
        held_prev  = held;
        file_flags = f;
        emits = eof;
        res   = '0;
        if (eof) begin
            res.has_tabs           = f.tabs;
            res.has_unusual_space  = f.unusual;
            res.has_trailing_space = f.trailing;
            res.has_crlf           = f.crlf;
            res.missing_final_lf   = (b != BYTE_LF);
            res.has_invalid_bytes  = f.invalid;
            res.can_be_fixed       = !f.invalid && (f.tabs || f.unusual || f.trailing ||
                                                    f.crlf || res.missing_final_lf);
            held_prev  = 8'h00;
            held_prev2 = 8'h00;
            file_flags = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof,
                             input bit pinned, input t_result outcome);
        bit      emits;
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!o_s_axis_tready);
        lint_byte(b, eof, emits, res);
        if (emits) begin
            pending_results.push_back(pinned ? outcome : res);
            files_sent++;
        end
        bytes_sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Appends one piece of text; clean files never raise a flag.
    task automatic add_token(input bit clean);
        int r;
        int v;
        r = $urandom_range(99);
        if (clean) begin
            if (r < 15) file_bytes.push_back(BYTE_SPACE);
            file_bytes.push_back(r < 75 ? printable_byte() : BYTE_LF);
        end else if (r < 40) begin
            file_bytes.push_back(printable_byte());
        end else if (r < 50) begin
            file_bytes.push_back(BYTE_SPACE);
        end else if (r < 60) begin
            file_bytes.push_back(BYTE_LF);
        end else if (r < 67) begin
            file_bytes.push_back(BYTE_CR);
            file_bytes.push_back(BYTE_LF);
        end else if (r < 71) begin
            file_bytes.push_back(BYTE_CR);
        end else if (r < 77) begin
            file_bytes.push_back(BYTE_TAB);
        end else if (r < 80) begin
            file_bytes.push_back(BYTE_VT);
        end else if (r < 82) begin
            file_bytes.push_back(BYTE_FF);
        end else if (r < 86) begin
            file_bytes.push_back(BYTE_SPACE);
            file_bytes.push_back(BYTE_LF);
        end else if (r < 89) begin
            file_bytes.push_back(BYTE_TAB);
            file_bytes.push_back(BYTE_CR);
            file_bytes.push_back(BYTE_LF);
        end else if (r < 94) begin
            // Control bytes that are not whitespace: 0x00-0x08 and 0x0E-0x1F.
            v = $urandom_range(0, 26);
            file_bytes.push_back(8'(v < 9 ? v : v + 5));
        end else begin
            file_bytes.push_back(8'($urandom_range(8'h7F, 8'hFF)));
        end
    endtask

    // A max_len of zero picks a mostly short length with the odd long file.
    task automatic make_file(input int max_len);
        int r;
        int len;
        bit noise;
        bit clean;
        file_bytes.delete();
        r     = $urandom_range(99);
        noise = (r < 10);
        clean = (r >= 10 && r < 30);
        if (max_len > 0) len = $urandom_range(1, max_len);
        else if ($urandom_range(99) < 5) len = $urandom_range(13, 60);
        else len = $urandom_range(1, 12);
        while (file_bytes.size() < len) begin
            if (noise) file_bytes.push_back(8'($urandom_range(0, 255)));
            else add_token(clean);
        end
        if (file_bytes[$] != BYTE_LF && (clean || (!noise && $urandom_range(1) == 1)))
            file_bytes.push_back(BYTE_LF);
    endtask

    task automatic send_file();
        foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("text_whitespace_lint_top test failed");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result word %h with none expected", $time, o_m_axis_tdata);
            end else begin
                want_word = {1'b0, pending_results.pop_front()};
                for (int k = 0; k < 8; k++) begin
                    if (o_m_axis_tdata[k] !== want_word[k]) begin
                        error_count++;
                        $display("%0t: %s expected %b actual %b", $time, result_field[k],
                                 want_word[k], o_m_axis_tdata[k]);
                    end
                end
                results_checked++;
            end
        end
    end

    initial begin
        int phase_start;
        send_idle_pct = 18;
        recv_idle_pct = 62;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_byte(directed_rows[k].text_byte, directed_rows[k].eof,
                      directed_rows[k].pinned, directed_rows[k].outcome);
        end
        drain();

        // Hold the output off while tiny files keep arriving, so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        repeat (30) begin
            make_file(2);
            send_file();
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 18 : 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 3) begin
                make_file(0);
                send_file();
            end
        end
        drain();

        $display("Streamed %0d bytes in %0d files under varied stalls, one long output hold",
                 bytes_sent, files_sent);
        $display("included; %0d flag words checked, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("text_whitespace_lint_top test passed");
        end else begin
            $display("text_whitespace_lint_top test failed");
        end
        $finish;
    end

endmodule
